// ===== rtl/axis_angle_vector_rotation_top_defines.svh =====
// Assertion macros for the axis-angle rotation block
`ifndef AXIS_ANGLE_VECTOR_ROTATION_TOP_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define AAVR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aavr assertion failed");
`define AAVR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aavr assertion failed");
`else
`define AAVR_ASSERT_IMPLY(lbl, ante, cons)
`define AAVR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/aavr_pkg.sv =====
// Shared types and constants of the axis-angle rotation block
package aavr_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int TURN_UNITS       = 23040;
  localparam int HALF_TURN_UNITS  = 11520;
  localparam int RAD_SCALE        = 9370165;
  localparam int CORDIC_GAIN      = 652032874;
  localparam int ANG_W            = 34;

  localparam logic [31:0] ATAN_Q30 [0:ATAN_ENTRIES-1] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic [31:0] vec_x;
    logic [31:0] vec_y;
    logic [31:0] vec_z;
    logic [15:0] axis_x;
    logic [15:0] axis_y;
    logic [15:0] axis_z;
  } payload_t;

  typedef struct packed {
    logic [31:0] vec_x;
    logic [31:0] vec_y;
    logic [31:0] vec_z;
    logic [8:0][31:0] m;
  } matrix_t;
endpackage

// ===== rtl/aavr_cordic.sv =====
// Unrolled rotation-mode CORDIC, one register stage per step
module aavr_cordic import aavr_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] in_z,
  input  payload_t                in_pay,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] out_cos,
  output logic signed [ANG_W-1:0] out_sin,
  output payload_t                out_pay
);
  logic                    valid_r [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] x_r     [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] y_r     [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] z_r     [0:CORDIC_STEPS];
  payload_t                pay_r   [0:CORDIC_STEPS];

  assign valid_r[0] = in_valid;
  assign x_r[0]     = ANG_W'(CORDIC_GAIN);
  assign y_r[0]     = '0;
  assign z_r[0]     = in_z;
  assign pay_r[0]   = in_pay;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [ANG_W-1:0] dx, dy, at;
    logic signed [ANG_W-1:0] x_nxt, y_nxt, z_nxt;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = $signed({2'b00, ATAN_Q30[i]});
    always_comb begin
      if (!z_r[i][ANG_W-1]) begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - at;
      end else begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + at;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else begin
        valid_r[i+1] <= valid_r[i];
      end
      x_r[i+1]   <= x_nxt;
      y_r[i+1]   <= y_nxt;
      z_r[i+1]   <= z_nxt;
      pay_r[i+1] <= pay_r[i];
    end
  end

  assign out_valid = valid_r[CORDIC_STEPS];
  assign out_cos   = x_r[CORDIC_STEPS];
  assign out_sin   = y_r[CORDIC_STEPS];
  assign out_pay   = pay_r[CORDIC_STEPS];
endmodule

// ===== rtl/aavr_quat.sv =====
// Quaternion forming, product and rotation-matrix stages
module aavr_quat import aavr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] in_cos,
  input  logic signed [ANG_W-1:0] in_sin,
  input  payload_t                in_pay,
  output logic                    out_valid,
  output matrix_t                 out_mat
);
  // quaternion stage, Q28
  logic               q_valid_r;
  logic signed [30:0] w_r, qx_r, qy_r, qz_r;
  logic [31:0]        qv_x_r, qv_y_r, qv_z_r;
  logic signed [ANG_W-1:0] w_sum;
  logic signed [49:0] ax_p, ay_p, az_p;

  assign w_sum = in_cos + ANG_W'(2);
  assign ax_p  = $signed(in_pay.axis_x) * in_sin + 50'sd32768;
  assign ay_p  = $signed(in_pay.axis_y) * in_sin + 50'sd32768;
  assign az_p  = $signed(in_pay.axis_z) * in_sin + 50'sd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= in_valid;
    end
    w_r    <= 31'(w_sum >>> 2);
    qx_r   <= 31'(ax_p >>> 16);
    qy_r   <= 31'(ay_p >>> 16);
    qz_r   <= 31'(az_p >>> 16);
    qv_x_r <= in_pay.vec_x;
    qv_y_r <= in_pay.vec_y;
    qv_z_r <= in_pay.vec_z;
  end

  // product stage, Q56
  logic               p_valid_r;
  logic signed [63:0] x2_r, y2_r, z2_r, w2_r, xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;
  logic [31:0]        pv_x_r, pv_y_r, pv_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= q_valid_r;
    end
    x2_r <= 64'(qx_r * qx_r);
    y2_r <= 64'(qy_r * qy_r);
    z2_r <= 64'(qz_r * qz_r);
    w2_r <= 64'(w_r * w_r);
    xy_r <= 64'(qx_r * qy_r);
    xz_r <= 64'(qx_r * qz_r);
    yz_r <= 64'(qy_r * qz_r);
    xw_r <= 64'(qx_r * w_r);
    yw_r <= 64'(qy_r * w_r);
    zw_r <= 64'(qz_r * w_r);
    pv_x_r <= qv_x_r;
    pv_y_r <= qv_y_r;
    pv_z_r <= qv_z_r;
  end

  // matrix stage, Q56 sums brought to Q24
  logic signed [63:0] m_sum [0:8];
  logic               m_valid_r;
  matrix_t            mat_r;

  always_comb begin
    m_sum[0] = w2_r + x2_r - y2_r - z2_r;
    m_sum[1] = 2 * xy_r - 2 * zw_r;
    m_sum[2] = 2 * xz_r + 2 * yw_r;
    m_sum[3] = 2 * xy_r + 2 * zw_r;
    m_sum[4] = w2_r - x2_r + y2_r - z2_r;
    m_sum[5] = 2 * yz_r - 2 * xw_r;
    m_sum[6] = 2 * xz_r - 2 * yw_r;
    m_sum[7] = 2 * yz_r + 2 * xw_r;
    m_sum[8] = w2_r - x2_r - y2_r + z2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= p_valid_r;
    end
    for (int k = 0; k < 9; k++) begin
      mat_r.m[k] <= 32'((m_sum[k] + 64'sh80000000) >>> 32);
    end
    mat_r.vec_x <= pv_x_r;
    mat_r.vec_y <= pv_y_r;
    mat_r.vec_z <= pv_z_r;
  end

  assign out_valid = m_valid_r;
  assign out_mat   = mat_r;
endmodule

// ===== rtl/aavr_xform.sv =====
// Matrix times vector, rounding and saturation
module aavr_xform import aavr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  matrix_t            in_mat,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  logic               v_valid_r;
  logic signed [63:0] pr_r [0:8];
  logic signed [31:0] vsel [0:2];

  assign vsel[0] = $signed(in_mat.vec_x);
  assign vsel[1] = $signed(in_mat.vec_y);
  assign vsel[2] = $signed(in_mat.vec_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_valid_r <= 1'b0;
    end else begin
      v_valid_r <= in_valid;
    end
    for (int k = 0; k < 9; k++) begin
      pr_r[k] <= $signed(in_mat.m[k]) * vsel[k % 3];
    end
  end

  logic signed [65:0] acc   [0:2];
  logic signed [41:0] rnd_v [0:2];
  logic signed [31:0] sat_v [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k]   = 66'(pr_r[3*k]) + 66'(pr_r[3*k+1]) + 66'(pr_r[3*k+2]) + 66'sh800000;
      rnd_v[k] = 42'(acc[k] >>> 24);
      if (rnd_v[k] > 42'sh7FFFFFFF) begin
        sat_v[k] = 32'sh7FFFFFFF;
      end else if (rnd_v[k] < -42'sh80000000) begin
        sat_v[k] = 32'sh80000000;
      end else begin
        sat_v[k] = 32'(rnd_v[k]);
      end
    end
  end

  logic               o_valid_r;
  logic signed [31:0] ox_r, oy_r, oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= v_valid_r;
    end
    ox_r <= sat_v[0];
    oy_r <= sat_v[1];
    oz_r <= sat_v[2];
  end

  assign out_valid = o_valid_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;
endmodule

// ===== rtl/axis_angle_vector_rotation_top.sv =====
// Path: an accepted word passes the wrap and half-angle registers, the CORDIC steps, then the quat and xform stages.
// Throughput: one word per cycle; busy stays low, every stage advances each cycle.
// The pipeline depth is set by the unrolled CORDIC, one step per stage.
// Reset: synchronous active-low rst_n clears all valid bits; data registers keep.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
`include "axis_angle_vector_rotation_top_defines.svh"
module axis_angle_vector_rotation_top import aavr_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic signed [15:0] in_turn_angle,
  output logic               out_valid,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z
);
  localparam int LAT = CORDIC_STEPS + 7;

  assign busy = 1'b0;

  // angle wrap into (-180, 180] degrees
  logic signed [16:0] u0, u1;
  logic signed [14:0] r_nxt;
  always_comb begin
    u0 = 17'(in_turn_angle);
    if (u0 < 0) begin
      u0 = u0 + 17'(TURN_UNITS);
    end
    if (u0 < 0) begin
      u1 = u0 + 17'(TURN_UNITS);
    end else if (u0 >= 17'(TURN_UNITS)) begin
      u1 = u0 - 17'(TURN_UNITS);
    end else begin
      u1 = u0;
    end
    if (u1 > 17'(HALF_TURN_UNITS)) begin
      r_nxt = 15'(u1 - 17'(TURN_UNITS));
    end else begin
      r_nxt = 15'(u1);
    end
  end

  logic               a_valid_r;
  logic signed [14:0] r_r;
  payload_t           a_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start & ~busy;
    end
    r_r     <= r_nxt;
    a_pay_r <= '{in_vec_x, in_vec_y, in_vec_z, in_axis_x, in_axis_y, in_axis_z};
  end

  // half angle in radians, Q30
  logic signed [40:0]      rad_p;
  logic                    b_valid_r;
  logic signed [ANG_W-1:0] z_r;
  payload_t                b_pay_r;

  assign rad_p = r_r * $signed(26'(RAD_SCALE)) + 41'sd32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    z_r     <= ANG_W'(rad_p >>> 6);
    b_pay_r <= a_pay_r;
  end

  logic                    c_valid;
  logic signed [ANG_W-1:0] c_cos, c_sin;
  payload_t                c_pay;

  aavr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (b_valid_r),
    .in_z     (z_r),
    .in_pay   (b_pay_r),
    .out_valid(c_valid),
    .out_cos  (c_cos),
    .out_sin  (c_sin),
    .out_pay  (c_pay)
  );

  logic    m_valid;
  matrix_t m_mat;

  aavr_quat u_quat (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (c_valid),
    .in_cos   (c_cos),
    .in_sin   (c_sin),
    .in_pay   (c_pay),
    .out_valid(m_valid),
    .out_mat  (m_mat)
  );

  aavr_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (m_valid),
    .in_mat   (m_mat),
    .out_valid(out_valid),
    .out_x    (out_rot_x),
    .out_y    (out_rot_y),
    .out_z    (out_rot_z)
  );

  `AAVR_ASSERT_IMPLY(a_word_latency, start, ##LAT out_valid)
  `AAVR_ASSERT_IMPLY(a_no_phantom, out_valid, $past(start && rst_n, LAT))
  `AAVR_ASSERT_IMPLY(a_zero_vec, start && in_vec_x == 0 && in_vec_y == 0 && in_vec_z == 0, ##LAT (out_rot_x == 0 && out_rot_y == 0 && out_rot_z == 0))
endmodule
